FILE: rtl/core/urie_pkg.sv
// Shared types, constants and helpers for the UART ring buffer engine.
// No dependencies; urie_ctrl, the top level and the testbench refer to this package.
`default_nettype none

package urie_pkg;

   localparam int DEPTH = 2048;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int BYTE_W = 8;

   typedef logic [PTR_W-1:0] ptr_type;
   typedef logic [BYTE_W-1:0] byte_type;

   typedef enum logic [1:0] {
      OP_RX       = 2'd0,
      OP_TX_EMPTY = 2'd1,
      OP_WRITE    = 2'd2,
      OP_READ     = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_RX_DROP  = 2'd1,
      ST_TX_FULL  = 2'd2,
      ST_RX_EMPTY = 2'd3
   } status_type;

   // Write and read port commands for one ring memory.
   typedef struct packed {
      logic     we;
      ptr_type  waddr;
      byte_type wdata;
      ptr_type  raddr;
   } ram_cmd_type;

   // Registered result controls; the bytes come from the memories, except a forwarded send byte.
   typedef struct packed {
      logic       strobe;
      status_type status;
      logic       send_valid;
      logic       send_fwd;
      byte_type   fwd_byte;
      logic       read_valid;
      logic       tx_irq;
      logic       done;
   } rsp_ctl_type;

   // Ring pointer advance with wrap at the ring depth.
   function automatic ptr_type ptr_next(input ptr_type ptr);
      ptr_type res;
      if (ptr == PTR_W'(DEPTH - 1)) begin
         res = '0;
      end else begin
         res = ptr + PTR_W'(1);
      end
      return res;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/urie_ring_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
// Depends on nothing; the depth and width come in as parameters.
`default_nettype none

module urie_ring_ram #(
   parameter int DEPTH_P = 2048,
   parameter int WIDTH_P = 8
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH_P)-1:0] wr_addr,
   input  wire logic [WIDTH_P-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH_P)-1:0] rd_addr,
   output logic      [WIDTH_P-1:0]         rd_data
);

   logic [WIDTH_P-1:0] mem_ff [DEPTH_P];
   logic [WIDTH_P-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read returns the old contents when the same entry is written at the same edge.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/core/urie_ctrl.sv
// Ring pointer control: decides each word's outcome and drives both ring memories.
// Depends on urie_pkg.
`default_nettype none

module urie_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire logic [1:0]            operation,
   input  wire urie_pkg::byte_type    data_byte,
   input  wire logic                  thr_empty,
   input  wire logic                  final_byte,
   output urie_pkg::ram_cmd_type      rx_cmd,
   output urie_pkg::ram_cmd_type      tx_cmd,
   output urie_pkg::rsp_ctl_type      rsp_ctl
);

   urie_pkg::ptr_type rx_wp_ff, rx_wp_in;
   urie_pkg::ptr_type rx_rp_ff, rx_rp_in;
   urie_pkg::ptr_type tx_wp_ff, tx_wp_in;
   urie_pkg::ptr_type tx_rp_ff, tx_rp_in;
   logic              tx_active_ff, tx_active_in;
   urie_pkg::rsp_ctl_type rsp_ff, rsp_in;

   urie_pkg::op_type  op;
   urie_pkg::ptr_type rx_nxt;
   urie_pkg::ptr_type tx_nxt;
   logic              rx_full;
   logic              tx_full;
   urie_pkg::ptr_type tx_wp_new;

   assign op      = urie_pkg::op_type'(operation);
   assign rx_nxt  = urie_pkg::ptr_next(rx_wp_ff);
   assign tx_nxt  = urie_pkg::ptr_next(tx_wp_ff);
   assign rx_full = (rx_nxt == rx_rp_ff);
   assign tx_full = (tx_nxt == tx_rp_ff);
   assign tx_wp_new = tx_full ? tx_wp_ff : tx_nxt;

   always_comb begin
      rx_wp_in     = rx_wp_ff;
      rx_rp_in     = rx_rp_ff;
      tx_wp_in     = tx_wp_ff;
      tx_rp_in     = tx_rp_ff;
      tx_active_in = tx_active_ff;

      rx_cmd.we    = 1'b0;
      rx_cmd.waddr = rx_wp_ff;
      rx_cmd.wdata = data_byte;
      rx_cmd.raddr = rx_rp_ff;
      tx_cmd.we    = 1'b0;
      tx_cmd.waddr = tx_wp_ff;
      tx_cmd.wdata = data_byte;
      tx_cmd.raddr = tx_rp_ff;

      rsp_in            = '0;
      rsp_in.status     = urie_pkg::ST_OK;
      rsp_in.fwd_byte   = data_byte;
      rsp_in.strobe     = accept;
      rsp_in.done       = final_byte;

      if (accept) begin
         case (op)
            urie_pkg::OP_RX: begin
               if (!rx_full) begin
                  rx_cmd.we = 1'b1;
                  rx_wp_in  = rx_nxt;
               end else begin
                  rsp_in.status = urie_pkg::ST_RX_DROP;
               end
            end
            urie_pkg::OP_TX_EMPTY: begin
               if (tx_wp_ff != tx_rp_ff) begin
                  rsp_in.send_valid = 1'b1;
                  tx_rp_in = urie_pkg::ptr_next(tx_rp_ff);
               end else begin
                  tx_active_in = 1'b0;
               end
            end
            urie_pkg::OP_WRITE: begin
               if (!tx_full) begin
                  tx_cmd.we = 1'b1;
                  tx_wp_in  = tx_nxt;
               end else begin
                  rsp_in.status = urie_pkg::ST_TX_FULL;
               end
               // Kick-start: an idle transmitter with queued data starts running.
               if (!tx_active_ff && (tx_wp_new != tx_rp_ff)) begin
                  tx_active_in = 1'b1;
                  if (thr_empty) begin
                     rsp_in.send_valid = 1'b1;
                     // An empty ring means the byte sent is the one written now.
                     rsp_in.send_fwd   = (tx_rp_ff == tx_wp_ff);
                     tx_rp_in = urie_pkg::ptr_next(tx_rp_ff);
                  end
               end
            end
            urie_pkg::OP_READ: begin
               if (rx_wp_ff != rx_rp_ff) begin
                  rsp_in.read_valid = 1'b1;
                  rx_rp_in = urie_pkg::ptr_next(rx_rp_ff);
               end else begin
                  rsp_in.status = urie_pkg::ST_RX_EMPTY;
               end
            end
            default: begin
               rsp_in.status = urie_pkg::ST_OK;
            end
         endcase
      end
      rsp_in.tx_irq = tx_active_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_wp_ff      <= '0;
         rx_rp_ff      <= '0;
         tx_wp_ff      <= '0;
         tx_rp_ff      <= '0;
         tx_active_ff  <= 1'b0;
         rsp_ff        <= '0;
      end else begin
         rx_wp_ff      <= rx_wp_in;
         rx_rp_ff      <= rx_rp_in;
         tx_wp_ff      <= tx_wp_in;
         tx_rp_ff      <= tx_rp_in;
         tx_active_ff  <= tx_active_in;
         rsp_ff        <= rsp_in;
      end
   end

   assign rsp_ctl = rsp_ff;

   a_send_read_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_ff.strobe |-> !(rsp_ff.send_valid && rsp_ff.read_valid))
      else $error("send and read both flagged in one result");

   a_fwd_needs_send: assert property (@(posedge clock) disable iff (reset)
      rsp_ff.send_fwd |-> rsp_ff.send_valid)
      else $error("forwarded byte without a send");

   a_drop_no_bytes: assert property (@(posedge clock) disable iff (reset)
      (rsp_ff.strobe && rsp_ff.status == urie_pkg::ST_RX_DROP)
         |-> (!rsp_ff.send_valid && !rsp_ff.read_valid))
      else $error("dropped receive byte came with a byte result");

   a_rx_store_nonempty: assert property (@(posedge clock) disable iff (reset)
      (accept && op == urie_pkg::OP_RX && !rx_full) |=> (rx_wp_ff != rx_rp_ff))
      else $error("receive ring empty after a stored byte");

   a_send_clears_irq_only_when_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_ff.strobe && rsp_ff.send_valid) |-> rsp_ff.tx_irq
         || $past(op) == urie_pkg::OP_TX_EMPTY)
      else $error("kick-start sent a byte without enabling the interrupt");

endmodule

`default_nettype wire

FILE: rtl/core/uart_ring_buffer_irq_engine_top.sv
// Top level of the UART receive/transmit ring buffer engine.
// Depends on urie_pkg, urie_ctrl and urie_ring_ram.
`default_nettype none

//  channel   | ports                                   | handshake
//  ----------+-----------------------------------------+------------------------------
//  request   | req_operation, req_data_byte,           | taken when start && !busy
//            | req_thr_empty, req_final_byte           |
//  response  | rsp_status, rsp_send_valid/byte,        | rsp_strobe high for one cycle
//            | rsp_read_valid/byte, rsp_tx_irq_enable, |
//            | rsp_request_done                        |
//
// One word is taken per clock cycle; its response is registered at the edge at which
// it was taken, matching the registered read port of each ring memory.
// The pointers live in flip-flops and are updated at the accepting edge, so the next word
// already sees them. A kick-start that sends the byte it has just queued into an empty
// ring takes that byte straight from the request rather than from the memory, which still
// holds old data. Reset clears the four ring pointers, the running flag and the response
// strobe; the ring memories are not cleared, as only entries between the pointers are
// ever read. busy is always low, and the receiver cannot stall the response.

module uart_ring_buffer_irq_engine_top (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire logic [1:0] req_operation,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_thr_empty,
   input  wire logic       req_final_byte,
   output logic            rsp_strobe,
   output logic [1:0]      rsp_status,
   output logic            rsp_send_valid,
   output logic [7:0]      rsp_send_byte,
   output logic            rsp_read_valid,
   output logic [7:0]      rsp_read_byte,
   output logic            rsp_tx_irq_enable,
   output logic            rsp_request_done
);

   logic                  accept;
   urie_pkg::ram_cmd_type rx_cmd;
   urie_pkg::ram_cmd_type tx_cmd;
   urie_pkg::rsp_ctl_type rsp_ctl;
   urie_pkg::byte_type    rx_rd_data;
   urie_pkg::byte_type    tx_rd_data;

   // busy is tied low, so the engine never refuses a word.
   assign busy   = 1'b0;
   assign accept = start && !busy;

   urie_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .operation  (req_operation),
      .data_byte  (req_data_byte),
      .thr_empty  (req_thr_empty),
      .final_byte (req_final_byte),
      .rx_cmd     (rx_cmd),
      .tx_cmd     (tx_cmd),
      .rsp_ctl    (rsp_ctl)
   );

   // Receive ring: written by received bytes, read by host reads.
   urie_ring_ram #(
      .DEPTH_P (urie_pkg::DEPTH),
      .WIDTH_P (urie_pkg::BYTE_W)
   ) u_rx_ram (
      .clock   (clock),
      .wr_en   (rx_cmd.we),
      .wr_addr (rx_cmd.waddr),
      .wr_data (rx_cmd.wdata),
      .rd_addr (rx_cmd.raddr),
      .rd_data (rx_rd_data)
   );

   // Transmit ring: written by host writes, read on transmitter-empty and kick-start.
   urie_ring_ram #(
      .DEPTH_P (urie_pkg::DEPTH),
      .WIDTH_P (urie_pkg::BYTE_W)
   ) u_tx_ram (
      .clock   (clock),
      .wr_en   (tx_cmd.we),
      .wr_addr (tx_cmd.waddr),
      .wr_data (tx_cmd.wdata),
      .rd_addr (tx_cmd.raddr),
      .rd_data (tx_rd_data)
   );

   assign rsp_strobe        = rsp_ctl.strobe;
   assign rsp_status        = rsp_ctl.status;
   assign rsp_send_valid    = rsp_ctl.send_valid;
   assign rsp_read_valid    = rsp_ctl.read_valid;
   assign rsp_tx_irq_enable = rsp_ctl.tx_irq;
   assign rsp_request_done  = rsp_ctl.done;

   // Byte fields read as zero when their valid flag is clear.
   always_comb begin
      if (!rsp_ctl.send_valid) begin
         rsp_send_byte = '0;
      end else if (rsp_ctl.send_fwd) begin
         rsp_send_byte = rsp_ctl.fwd_byte;
      end else begin
         rsp_send_byte = tx_rd_data;
      end
      rsp_read_byte = rsp_ctl.read_valid ? rx_rd_data : '0;
   end

endmodule

`default_nettype wire

FILE: dv/tb_uart_ring_buffer_irq_engine_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the UART receive/transmit ring buffer engine.
// It depends on urie_pkg and uart_ring_buffer_irq_engine_top. A behavioural copy of both rings
// predicts every response word not typed in the opening table; each is checked field by field.

module tb_uart_ring_buffer_irq_engine_top;
   import urie_pkg::*;

   // Number of words in the mixed traffic that follows the transmit ring fill sequence.
   localparam int MIXED_WORDS = 200;

   // One response word as the block presents it on the rsp_ ports.
   typedef struct packed {
      status_type status;
      logic       send_valid;
      byte_type   send_byte;
      logic       read_valid;
      byte_type   read_byte;
      logic       tx_irq;
      logic       done;
   } rsp_word_type;

   // One row of the opening stimulus table. Where typed is set, the response is written out
   // by hand in want; otherwise it comes from the ring predictor.
   typedef struct {
      op_type       op;
      byte_type     data;
      logic         thr;
      logic         fin;
      logic         typed;
      rsp_word_type want;
   } stim_row_type;

   // Every input is given a known value from time zero, reset included.
   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   logic [1:0] req_operation = 2'd0;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_thr_empty = 1'b0;
   logic       req_final_byte = 1'b0;
   logic       rsp_strobe;
   logic [1:0] rsp_status;
   logic       rsp_send_valid;
   logic [7:0] rsp_send_byte;
   logic       rsp_read_valid;
   logic [7:0] rsp_read_byte;
   logic       rsp_tx_irq_enable;
   logic       rsp_request_done;

   // Side information that travels with the word on the request ports: whether its response
   // is typed in the table, and if so what it is.
   logic         row_typed = 1'b0;
   rsp_word_type row_want = '0;

   // Predictor state: both rings, their pointers, the running flag and the TX interrupt enable.
   // The ring contents need no reset value, since only slots between the pointers are read.
   byte_type rx_ring [DEPTH];
   byte_type tx_ring [DEPTH];
   ptr_type  rx_wr = '0;
   ptr_type  rx_rd = '0;
   ptr_type  tx_wr = '0;
   ptr_type  tx_rd = '0;
   logic     tx_on = 1'b0;
   logic     tx_ie = 1'b0;

   rsp_word_type rsp_due [$];
   stim_row_type opening_rows [$];
   int           bad_count = 0;
   int           burst_left = 0;

   uart_ring_buffer_irq_engine_top DUT (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_operation     (req_operation),
      .req_data_byte     (req_data_byte),
      .req_thr_empty     (req_thr_empty),
      .req_final_byte    (req_final_byte),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_send_valid    (rsp_send_valid),
      .rsp_send_byte     (rsp_send_byte),
      .rsp_read_valid    (rsp_read_valid),
      .rsp_read_byte     (rsp_read_byte),
      .rsp_tx_irq_enable (rsp_tx_irq_enable),
      .rsp_request_done  (rsp_request_done)
   );

   // 10 ns clock, high and low for 5 ns each.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The run is cut short after a generous fixed time, well beyond the slowest correct run
   // of roughly two thousand three hundred words with their idle gaps.
   initial begin
      #20_000_000;
      $display("Mismatches found");
      $finish;
   end

   // Ring pointer advance, wrapping at the ring depth.
   function automatic ptr_type ring_after(input ptr_type p);
      return ptr_type'((int'(p) + 1) % DEPTH);
   endfunction

   // Applies one word to the predicted ring state and returns the response it causes.
   function automatic rsp_word_type uart_rings_next(input op_type op, input byte_type data,
                                                   input logic thr, input logic fin);
      rsp_word_type r;
      r = '0;
      r.status = ST_OK;
      r.done = fin;
      case (op)
         OP_RX: begin
            // A full receive ring drops the byte.
            if (ring_after(rx_wr) != rx_rd) begin
               rx_ring[rx_wr] = data;
               rx_wr = ring_after(rx_wr);
            end else begin
               r.status = ST_RX_DROP;
            end
         end
         OP_TX_EMPTY: begin
            // The holding register has room: send the oldest byte, or stop when none waits.
            if (tx_wr != tx_rd) begin
               r.send_valid = 1'b1;
               r.send_byte = tx_ring[tx_rd];
               tx_rd = ring_after(tx_rd);
            end else begin
               tx_on = 1'b0;
               tx_ie = 1'b0;
            end
         end
         OP_WRITE: begin
            if (ring_after(tx_wr) != tx_rd) begin
               tx_ring[tx_wr] = data;
               tx_wr = ring_after(tx_wr);
            end else begin
               r.status = ST_TX_FULL;
            end
            // Kick-start: an idle transmitter with bytes queued is started, and the oldest
            // byte goes out at once only if the holding register is empty.
            if (!tx_on && tx_wr != tx_rd) begin
               tx_on = 1'b1;
               tx_ie = 1'b1;
               if (thr) begin
                  r.send_valid = 1'b1;
                  r.send_byte = tx_ring[tx_rd];
                  tx_rd = ring_after(tx_rd);
               end
            end
         end
         default: begin
            if (rx_wr != rx_rd) begin
               r.read_valid = 1'b1;
               r.read_byte = rx_ring[rx_rd];
               rx_rd = ring_after(rx_rd);
            end else begin
               r.status = ST_RX_EMPTY;
            end
         end
      endcase
      r.tx_irq = tx_ie;
      return r;
   endfunction

   // Adds a row to the opening table; the expected fields matter only when typed is set.
   task automatic plan_row(input op_type op, input byte_type data, input logic thr,
                           input logic fin, input logic typed, input status_type st,
                           input logic sv, input byte_type sb, input logic rv,
                           input byte_type rb, input logic ie);
      stim_row_type row;
      row.op = op;
      row.data = data;
      row.thr = thr;
      row.fin = fin;
      row.typed = typed;
      row.want.status = st;
      row.want.send_valid = sv;
      row.want.send_byte = sb;
      row.want.read_valid = rv;
      row.want.read_byte = rb;
      row.want.tx_irq = ie;
      row.want.done = fin;
      opening_rows.push_back(row);
   endtask

   // Presents one word at a falling edge and returns at the rising edge that takes it.
   // The sender works in bursts: once a burst is used up it idles with start low and then
   // draws a new burst length, now and then a long one so that stretches without gaps occur.
   task automatic send_word(input op_type op, input byte_type data, input logic thr,
                            input logic fin, input logic typed, input rsp_word_type want);
      if (burst_left == 0) begin
         repeat ($urandom_range(1, 6)) begin
            @(negedge clock);
            start = 1'b0;
         end
         burst_left = ($urandom_range(0, 7) == 0) ? int'($urandom_range(60, 250))
                                                  : int'($urandom_range(1, 12));
      end
      burst_left--;
      @(negedge clock);
      start = 1'b1;
      req_operation = op;
      req_data_byte = data;
      req_thr_empty = thr;
      req_final_byte = fin;
      row_typed = typed;
      row_want = want;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
   endtask

   // Stops sending and waits until every outstanding response word has arrived.
   task automatic hold_until_drained();
      @(negedge clock);
      start = 1'b0;
      while (rsp_due.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // Response checker and predictor, both at the rising edge. The response to a word taken
   // at one edge is strobed in the following cycle, so it is checked at the next edge; the
   // check runs before the new word's expectation is queued, which keeps the order plain.
   always @(posedge clock) begin
      rsp_word_type seen;
      rsp_word_type want;
      if (!reset) begin
         seen.status = status_type'(rsp_status);
         seen.send_valid = rsp_send_valid;
         seen.send_byte = rsp_send_byte;
         seen.read_valid = rsp_read_valid;
         seen.read_byte = rsp_read_byte;
         seen.tx_irq = rsp_tx_irq_enable;
         seen.done = rsp_request_done;
         if (rsp_strobe === 1'b1) begin
            if (rsp_due.size() == 0) begin
               bad_count++;
               if (bad_count <= 10) begin
                  $display("%0t: response strobe with no word outstanding", $time);
               end
            end else begin
               want = rsp_due.pop_front();
               if (seen.status !== want.status || seen.send_valid !== want.send_valid ||
                   seen.send_byte !== want.send_byte || seen.read_valid !== want.read_valid ||
                   seen.read_byte !== want.read_byte || seen.tx_irq !== want.tx_irq ||
                   seen.done !== want.done) begin
                  bad_count++;
                  if (bad_count <= 10) begin
                     $display("%0t: expected st=%0d sv=%0d sb=%02h rv=%0d rb=%02h ie=%0d dn=%0d",
                              $time, want.status, want.send_valid, want.send_byte,
                              want.read_valid, want.read_byte, want.tx_irq, want.done);
                     $display("%0t:   actual st=%0d sv=%0d sb=%02h rv=%0d rb=%02h ie=%0d dn=%0d",
                              $time, rsp_status, rsp_send_valid, rsp_send_byte,
                              rsp_read_valid, rsp_read_byte, rsp_tx_irq_enable,
                              rsp_request_done);
                  end
               end
            end
         end
         if (start && !busy) begin
            // The predictor sees every word, typed or not, so that its state stays in step.
            want = uart_rings_next(op_type'(req_operation), req_data_byte, req_thr_empty,
                                   req_final_byte);
            rsp_due.push_back(row_typed ? row_want : want);
         end
      end
   end

   initial begin
      int          extra;
      int          mode;
      int          mode_left;
      int          pick;
      int          waited;
      op_type      op;
      stim_row_type row;

      // Opening table. Rows with a response typed in are read off at a glance: the state after
      // reset, data extremes, the empty-read status and kick-starts. The rest are predicted.
      // Empty receive ring right after reset, and a transmitter-empty event while idle.
      plan_row(OP_READ,     8'h00, 1'b0, 1'b1, 1'b1, ST_RX_EMPTY, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0);
      plan_row(OP_TX_EMPTY, 8'h00, 1'b1, 1'b0, 1'b1, ST_OK,       1'b0, 8'h00, 1'b0, 8'h00, 1'b0);
      // Received bytes at both extremes, read back in order, then an empty read.
      plan_row(OP_RX,       8'h00, 1'b0, 1'b0, 1'b1, ST_OK,       1'b0, 8'h00, 1'b0, 8'h00, 1'b0);
      plan_row(OP_RX,       8'hFF, 1'b1, 1'b1, 1'b1, ST_OK,       1'b0, 8'h00, 1'b0, 8'h00, 1'b0);
      plan_row(OP_READ,     8'h00, 1'b0, 1'b0, 1'b1, ST_OK,       1'b0, 8'h00, 1'b1, 8'h00, 1'b0);
      plan_row(OP_READ,     8'hFF, 1'b1, 1'b1, 1'b1, ST_OK,       1'b0, 8'h00, 1'b1, 8'hFF, 1'b0);
      plan_row(OP_READ,     8'h00, 1'b0, 1'b0, 1'b1, ST_RX_EMPTY, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0);
      // Kick-start into an empty ring with the holding register free: the byte just queued
      // goes out in the same word. The next transmitter-empty event finds nothing and stops.
      plan_row(OP_WRITE,    8'hFF, 1'b1, 1'b1, 1'b1, ST_OK,       1'b1, 8'hFF, 1'b0, 8'h00, 1'b1);
      plan_row(OP_TX_EMPTY, 8'h00, 1'b0, 1'b0, 1'b1, ST_OK,       1'b0, 8'h00, 1'b0, 8'h00, 1'b0);
      // Kick-start with the holding register busy: the interrupt is enabled, nothing sent.
      plan_row(OP_WRITE,    8'h00, 1'b0, 1'b1, 1'b1, ST_OK,       1'b0, 8'h00, 1'b0, 8'h00, 1'b1);
      // Writes while running queue only; the events then send them in order.
      plan_row(OP_WRITE,    8'hA5, 1'b1, 1'b0, 1'b0, ST_OK,       1'b0, 8'h00, 1'b0, 8'h00, 1'b0);
      plan_row(OP_WRITE,    8'h5A, 1'b0, 1'b1, 1'b0, ST_OK,       1'b0, 8'h00, 1'b0, 8'h00, 1'b0);
      plan_row(OP_TX_EMPTY, 8'h00, 1'b0, 1'b0, 1'b0, ST_OK,       1'b0, 8'h00, 1'b0, 8'h00, 1'b0);
      plan_row(OP_TX_EMPTY, 8'hFF, 1'b1, 1'b1, 1'b0, ST_OK,       1'b0, 8'h00, 1'b0, 8'h00, 1'b0);
      plan_row(OP_WRITE,    8'h3C, 1'b1, 1'b0, 1'b0, ST_OK,       1'b0, 8'h00, 1'b0, 8'h00, 1'b0);
      plan_row(OP_TX_EMPTY, 8'h00, 1'b0, 1'b1, 1'b0, ST_OK,       1'b0, 8'h00, 1'b0, 8'h00, 1'b0);
      plan_row(OP_TX_EMPTY, 8'h00, 1'b1, 1'b0, 1'b0, ST_OK,       1'b0, 8'h00, 1'b0, 8'h00, 1'b0);
      plan_row(OP_TX_EMPTY, 8'h00, 1'b0, 1'b1, 1'b1, ST_OK,       1'b0, 8'h00, 1'b0, 8'h00, 1'b0);
      // Interleaved receive, host read and a forwarded zero byte.
      plan_row(OP_RX,       8'h81, 1'b1, 1'b0, 1'b0, ST_OK,       1'b0, 8'h00, 1'b0, 8'h00, 1'b0);
      plan_row(OP_RX,       8'h7E, 1'b0, 1'b1, 1'b0, ST_OK,       1'b0, 8'h00, 1'b0, 8'h00, 1'b0);
      plan_row(OP_READ,     8'h00, 1'b1, 1'b0, 1'b0, ST_OK,       1'b0, 8'h00, 1'b0, 8'h00, 1'b0);
      plan_row(OP_WRITE,    8'h00, 1'b1, 1'b0, 1'b0, ST_OK,       1'b0, 8'h00, 1'b0, 8'h00, 1'b0);
      plan_row(OP_READ,     8'h55, 1'b0, 1'b1, 1'b0, ST_OK,       1'b0, 8'h00, 1'b0, 8'h00, 1'b0);
      plan_row(OP_READ,     8'hAA, 1'b1, 1'b1, 1'b0, ST_OK,       1'b0, 8'h00, 1'b0, 8'h00, 1'b0);
      plan_row(OP_TX_EMPTY, 8'h00, 1'b1, 1'b0, 1'b0, ST_OK,       1'b0, 8'h00, 1'b0, 8'h00, 1'b0);

      // Synchronous reset, released at a falling edge.
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (opening_rows[i]) begin
         row = opening_rows[i];
         send_word(row.op, row.data, row.thr, row.fin, row.typed, row.want);
      end
      hold_until_drained();

      // Transmit ring: host writes with no transmitter-empty events until it is full and
      // writes are refused; the mixed traffic that follows starts from this full ring.
      extra = $urandom_range(2, 5);
      repeat (DEPTH + extra) begin
         send_word(OP_WRITE, byte_type'($urandom), 1'($urandom), 1'($urandom), 1'b0, '0);
      end
      hold_until_drained();

      // Mixed traffic in stretches, each but the neutral ones leaning towards one operation;
      // the neutral stretches draw all four alike.
      mode = 0;
      mode_left = 0;
      for (int n = 0; n < MIXED_WORDS; n++) begin
         if (mode_left == 0) begin
            mode = $urandom_range(0, 4);
            mode_left = $urandom_range(20, 120);
         end
         mode_left--;
         pick = $urandom_range(0, 99);
         op = op_type'(pick % 4);
         if (pick < 70) begin
            case (mode)
               1: op = OP_RX;
               2: op = OP_READ;
               3: op = OP_WRITE;
               4: op = OP_TX_EMPTY;
               default: op = op_type'(pick % 4);
            endcase
         end
         send_word(op, byte_type'($urandom), 1'($urandom), 1'($urandom), 1'b0, '0);
         if (n == MIXED_WORDS / 2) begin
            hold_until_drained();
         end
      end

      // Wind down: wait for the last responses, with a bound, then keep watching in case a
      // stray strobe follows. Anything still outstanding counts as a failure.
      @(negedge clock);
      start = 1'b0;
      waited = 0;
      while (rsp_due.size() != 0 && waited < 100) begin
         @(posedge clock);
         waited++;
      end
      repeat (5) @(posedge clock);
      bad_count += rsp_due.size();
      if (bad_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

FILE: uart_ring_buffer_irq_engine_top.f
rtl/core/urie_pkg.sv
rtl/core/urie_ring_ram.sv
rtl/core/urie_ctrl.sv
rtl/core/uart_ring_buffer_irq_engine_top.sv
dv/tb_uart_ring_buffer_irq_engine_top.sv
